[design/keyword_lexer_stream_defines.svh]
// ----------------------------------------------------------------------------
// Keyword lexer stream assertion macros
// Shared concurrent assertion forms for the lexer checker.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_LEXER_STREAM_DEFINES_SVH
`define KEYWORD_LEXER_STREAM_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define KLX_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Next-cycle implication checked outside reset.
`define KLX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

[design/klx_pkg.sv]
// ----------------------------------------------------------------------------
// Keyword lexer package
// Token kinds, scan modes, keyword lookup and character classes.
// ----------------------------------------------------------------------------
`default_nettype none
package klx_pkg;

    localparam int KIND_W = 5;
    localparam int POS_W  = 16;
    localparam int MAX_KEEP = 15;

    localparam logic [4:0] K_DEVICE   = 5'd0;
    localparam logic [4:0] K_SENSOR   = 5'd1;
    localparam logic [4:0] K_PIN      = 5'd2;
    localparam logic [4:0] K_TURN     = 5'd3;
    localparam logic [4:0] K_ON       = 5'd4;
    localparam logic [4:0] K_OFF      = 5'd5;
    localparam logic [4:0] K_WAIT     = 5'd6;
    localparam logic [4:0] K_IF       = 5'd7;
    localparam logic [4:0] K_WHEN     = 5'd8;
    localparam logic [4:0] K_DETECTED = 5'd9;
    localparam logic [4:0] K_NOTDET   = 5'd10;
    localparam logic [4:0] K_LIGAR    = 5'd11;
    localparam logic [4:0] K_DESLIGAR = 5'd12;
    localparam logic [4:0] K_IDENT    = 5'd13;
    localparam logic [4:0] K_NUMBER   = 5'd14;
    localparam logic [4:0] K_ANALOG   = 5'd15;
    localparam logic [4:0] K_EQ       = 5'd16;
    localparam logic [4:0] K_NE       = 5'd17;
    localparam logic [4:0] K_GT       = 5'd18;
    localparam logic [4:0] K_LT       = 5'd19;
    localparam logic [4:0] K_GE       = 5'd20;
    localparam logic [4:0] K_LE       = 5'd21;
    localparam logic [4:0] K_LBRACE   = 5'd22;
    localparam logic [4:0] K_RBRACE   = 5'd23;
    localparam logic [4:0] K_SEMI     = 5'd24;
    localparam logic [4:0] K_EOF      = 5'd25;
    localparam logic [4:0] K_ERROR    = 5'd26;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [2:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_AFIRST, M_ANALOG, M_OPER, M_SLASH, M_COMMENT
    } scan_mode_t;

    // One emitted token before packing
    typedef struct packed {
        logic [4:0]   kind;
        logic [15:0]  line;
        logic [15:0]  column;
        logic [119:0] text;
        logic [3:0]   len;
    } token_t;

    // Up to two tokens produced by one transfer
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        token_t tok0;
        token_t tok1;
    } emit_pair_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5f;
    endfunction

    // Compare kept text with one keyword; text packed byte 0 in low bits
    function automatic logic kw_hit(input logic [119:0] txt, input logic [3:0] len,
                                    input logic [103:0] word, input logic [3:0] wlen);
        logic [119:0] mask;
        mask = '0;
        for (int i = 0; i < 15; i++) begin
            if (4'(i) < wlen) mask[i*8 +: 8] = 8'hff;
        end
        return (len == wlen) && ((txt & mask) == ({16'h0, word} & mask));
    endfunction

    // Keyword lookup; words given reversed so the first letter is in the low byte
    function automatic logic [4:0] keyword_kind(input logic [119:0] t, input logic [3:0] n);
        logic [4:0] k;
        k = K_IDENT;
        if (kw_hit(t, n, 104'({<<8{"device"}}), 4'd6))        k = K_DEVICE;
        if (kw_hit(t, n, 104'({<<8{"sensor"}}), 4'd6))        k = K_SENSOR;
        if (kw_hit(t, n, 104'({<<8{"pin"}}), 4'd3))           k = K_PIN;
        if (kw_hit(t, n, 104'({<<8{"turn"}}), 4'd4))          k = K_TURN;
        if (kw_hit(t, n, 104'({<<8{"on"}}), 4'd2))            k = K_ON;
        if (kw_hit(t, n, 104'({<<8{"off"}}), 4'd3))           k = K_OFF;
        if (kw_hit(t, n, 104'({<<8{"wait"}}), 4'd4))          k = K_WAIT;
        if (kw_hit(t, n, 104'({<<8{"if"}}), 4'd2))            k = K_IF;
        if (kw_hit(t, n, 104'({<<8{"when"}}), 4'd4))          k = K_WHEN;
        if (kw_hit(t, n, 104'({<<8{"detected"}}), 4'd8))      k = K_DETECTED;
        if (kw_hit(t, n, 104'({<<8{{"not_", "detected"}}}), 4'd12)) k = K_NOTDET;
        if (kw_hit(t, n, 104'({<<8{"dispositivo"}}), 4'd11))  k = K_DEVICE;
        if (kw_hit(t, n, 104'({<<8{"pino"}}), 4'd4))          k = K_PIN;
        if (kw_hit(t, n, 104'({<<8{"ligar"}}), 4'd5))         k = K_LIGAR;
        if (kw_hit(t, n, 104'({<<8{"desligar"}}), 4'd8))      k = K_DESLIGAR;
        if (kw_hit(t, n, 104'({<<8{"esperar"}}), 4'd7))       k = K_WAIT;
        if (kw_hit(t, n, 104'({<<8{"se"}}), 4'd2))            k = K_IF;
        if (kw_hit(t, n, 104'({<<8{"quando"}}), 4'd6))        k = K_WHEN;
        if (kw_hit(t, n, 104'({<<8{"detectado"}}), 4'd9))     k = K_DETECTED;
        if (kw_hit(t, n, 104'({<<8{{"nao_", "detectado"}}}), 4'd13)) k = K_NOTDET;
        return k;
    endfunction

endpackage
`default_nettype wire

[design/klx_scanner.sv]
// ----------------------------------------------------------------------------
// Keyword lexer scanner
// Scan state and token building; one source transfer per cycle while in_fire is high.
// ----------------------------------------------------------------------------
`default_nettype none
module klx_scanner import klx_pkg::*; #(
    parameter int TEXT_BYTES = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic       in_cmd,
    input  wire logic [7:0] in_char,
    output emit_pair_t      emit_out
);
    localparam int KEEP = TEXT_BYTES - 1;
    localparam int CNT_W = $clog2(TEXT_BYTES);

    scan_mode_t         mode_reg, mode_next;
    logic [7:0]         store_reg [TEXT_BYTES];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [7:0]         oper_reg, oper_next;
    logic [15:0]        cur_line_reg, cur_line_next;
    logic [15:0]        cur_col_reg, cur_col_next;
    logic [15:0]        tok_line_reg, tok_line_next;
    logic [15:0]        tok_col_reg, tok_col_next;
    logic               wr_en;
    logic [CNT_W-1:0]   wr_idx;
    logic [119:0]       kept;
    logic [3:0]         kept_len;
    token_t             flush_tok;
    logic               flush_v;
    emit_pair_t         e;

    // Gather kept text, zeroing bytes beyond the count
    always_comb begin
        kept = '0;
        for (int i = 0; i < MAX_KEEP; i++) begin
            if (i < KEEP && CNT_W'(i) < count_reg) kept[i*8 +: 8] = store_reg[i];
        end
        kept_len = 4'(count_reg);
    end

    // Token pending in the current mode
    always_comb begin
        flush_tok = '{kind: K_IDENT, line: tok_line_reg, column: tok_col_reg,
                      text: kept, len: kept_len};
        flush_v = 1'b1;
        case (mode_reg)
            M_IDENT, M_AFIRST: flush_tok.kind = keyword_kind(kept, kept_len);
            M_NUMBER: flush_tok.kind = K_NUMBER;
            M_ANALOG: flush_tok.kind = K_ANALOG;
            M_OPER: begin
                flush_tok.kind = (oper_reg == 8'h3e) ? K_GT :
                                 (oper_reg == 8'h3c) ? K_LT : K_ERROR;
                flush_tok.text = {112'h0, oper_reg};
                flush_tok.len  = 4'd1;
            end
            M_SLASH: begin
                flush_tok.kind = K_ERROR;
                flush_tok.text = {112'h0, 8'h2f};
                flush_tok.len  = 4'd1;
            end
            default: flush_v = 1'b0;
        endcase
    end

    // Next state and emitted tokens
    always_comb begin
        logic       do_idle;
        logic       do_flush;
        logic       app;
        token_t     single;
        logic       single_v;
        logic [7:0] c;
        c = in_char;
        mode_next = mode_reg;
        count_next = count_reg;
        oper_next = oper_reg;
        cur_line_next = cur_line_reg;
        cur_col_next = cur_col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next = tok_col_reg;
        wr_en = 1'b0;
        wr_idx = count_reg;
        e = '0;
        do_idle = 1'b0;
        do_flush = 1'b0;
        app = 1'b0;
        single = '{kind: K_ERROR, line: cur_line_reg, column: cur_col_reg,
                   text: {112'h0, c}, len: 4'd1};
        single_v = 1'b0;
        if (in_cmd == CMD_END) begin
            // Flush, emit EOF, return to reset state
            e.valid0 = 1'b1;
            e.tok0 = '{kind: K_EOF, line: cur_line_reg, column: cur_col_reg,
                       text: {96'h0, 8'h46, 8'h4f, 8'h45}, len: 4'd3};
            if (flush_v) begin
                e.tok1 = e.tok0;
                e.valid1 = 1'b1;
                e.tok0 = flush_tok;
            end
            mode_next = M_IDLE;
            count_next = '0;
            oper_next = '0;
            cur_line_next = 16'd1;
            cur_col_next = '0;
            tok_line_next = 16'd1;
            tok_col_next = '0;
        end else begin
            if (c == 8'h0a) begin
                if (cur_line_reg != 16'hffff) cur_line_next = cur_line_reg + 16'd1;
                cur_col_next = '0;
            end else if (cur_col_reg != 16'hffff) begin
                cur_col_next = cur_col_reg + 16'd1;
            end
            single.line = cur_line_next;
            single.column = cur_col_next;
            case (mode_reg)
                M_AFIRST: begin
                    if (is_digit(c)) begin
                        app = 1'b1; mode_next = M_ANALOG;
                    end else if (is_word(c)) begin
                        app = 1'b1; mode_next = M_IDENT;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word(c)) app = 1'b1;
                    else begin do_flush = 1'b1; do_idle = 1'b1; end
                end
                M_NUMBER, M_ANALOG: begin
                    if (is_digit(c)) app = 1'b1;
                    else begin do_flush = 1'b1; do_idle = 1'b1; end
                end
                M_OPER: begin
                    if (c == 8'h3d) begin
                        e.valid0 = 1'b1;
                        e.tok0 = '{kind: (oper_reg == 8'h3d) ? K_EQ :
                                         (oper_reg == 8'h21) ? K_NE :
                                         (oper_reg == 8'h3e) ? K_GE : K_LE,
                                   line: tok_line_reg, column: tok_col_reg,
                                   text: {104'h0, 8'h3d, oper_reg}, len: 4'd2};
                        mode_next = M_IDLE;
                    end else begin
                        do_flush = 1'b1; do_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == 8'h2f) mode_next = M_COMMENT;
                    else begin do_flush = 1'b1; do_idle = 1'b1; end
                end
                M_COMMENT: begin
                    if (c == 8'h0a) mode_next = M_IDLE;
                end
                default: do_idle = 1'b1;
            endcase
            if (do_flush) begin
                mode_next = M_IDLE;
                count_next = '0;
            end
            if (do_idle) begin
                // Skip whitespace, start a token or emit a single-byte one
                if (c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
                    mode_next = M_IDLE;
                end else if (c == 8'h2f || c == 8'h41 || is_alpha(c) || c == 8'h5f ||
                             is_digit(c) || c == 8'h3d || c == 8'h21 || c == 8'h3e ||
                             c == 8'h3c) begin
                    count_next = '0;
                    tok_line_next = cur_line_next;
                    tok_col_next = cur_col_next;
                    if (c == 8'h2f) mode_next = M_SLASH;
                    else if (c == 8'h41) mode_next = M_AFIRST;
                    else if (is_alpha(c) || c == 8'h5f) mode_next = M_IDENT;
                    else if (is_digit(c)) mode_next = M_NUMBER;
                    else begin
                        mode_next = M_OPER;
                        oper_next = c;
                    end
                    if (c != 8'h2f && !(mode_next == M_OPER)) begin
                        wr_en = 1'b1;
                        wr_idx = '0;
                        count_next = CNT_W'(1);
                    end
                end else begin
                    mode_next = M_IDLE;
                    single_v = 1'b1;
                    single.kind = (c == 8'h7b) ? K_LBRACE : (c == 8'h7d) ? K_RBRACE :
                                  (c == 8'h3b) ? K_SEMI : K_ERROR;
                end
            end
            if (app && count_reg < CNT_W'(KEEP)) begin
                wr_en = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            // Order: flushed token first, then single-byte token
            if (do_flush && flush_v) begin
                e.valid0 = 1'b1;
                e.tok0 = flush_tok;
                if (single_v) begin
                    e.valid1 = 1'b1;
                    e.tok1 = single;
                end
            end else if (single_v) begin
                e.valid0 = 1'b1;
                e.tok0 = single;
            end
        end
    end

    assign emit_out = e;

    // Hold state; advance on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            count_reg <= '0;
            oper_reg <= '0;
            cur_line_reg <= 16'd1;
            cur_col_reg <= '0;
            tok_line_reg <= 16'd1;
            tok_col_reg <= '0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            count_reg <= count_next;
            oper_reg <= oper_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg <= cur_col_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg <= tok_col_next;
        end
    end

    // Text store write
    always_ff @(posedge aclk) begin
        if (in_fire && wr_en && in_cmd == CMD_BYTE) store_reg[wr_idx] <= in_char;
    end

endmodule
`default_nettype wire

[design/klx_out_queue.sv]
// ----------------------------------------------------------------------------
// Keyword lexer output queue
// Four-entry token queue that parts the scanner from the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
module klx_out_queue import klx_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire emit_pair_t pair,
    output logic        room,
    output logic        out_valid,
    input  wire logic   out_ready,
    output token_t      out_tok,
    output logic        out_last
);
    // Each entry: token plus last flag
    token_t     tok_reg [4];
    logic       last_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic       pop;
    logic [1:0] n_push;

    assign pop = out_valid && out_ready;
    assign n_push = push ? (2'(pair.valid0) + 2'(pair.valid1)) : 2'd0;
    // Accept only while two entries are free before this cycle's pop
    assign room = cnt_reg <= 3'd2;
    assign out_valid = cnt_reg != 3'd0;
    assign out_tok = tok_reg[rd_reg];
    assign out_last = last_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg <= rd_reg + 2'(pop);
            wr_reg <= wr_reg + n_push;
            cnt_reg <= cnt_reg + 3'(n_push) - 3'(pop);
        end
    end

    // Write up to two entries
    always_ff @(posedge aclk) begin
        if (push && pair.valid0) begin
            tok_reg[wr_reg] <= pair.tok0;
            last_reg[wr_reg] <= !pair.valid1;
        end
        if (push && pair.valid1) begin
            tok_reg[wr_reg + 2'd1] <= pair.tok1;
            last_reg[wr_reg + 2'd1] <= 1'b1;
        end
    end

endmodule
`default_nettype wire

[design/keyword_lexer_stream.sv]
// ----------------------------------------------------------------------------
// Keyword lexer stream
// Top level: input register, scanner and token queue.
// ----------------------------------------------------------------------------
// Usage: send source bytes on the s_ channel (tuser = 0, tdata = byte), and an
// end-of-input transfer (tuser = 1) to close the stream. Tokens come out on the
// m_ channel, one per transfer, with tlast on the final token that one input
// transfer caused. Bytes that only extend a token or are skipped give nothing.
// An input transfer is registered once, then scanned, and its tokens enter a
// four-entry queue whose head drives the m_ channel. Throughput: one byte per
// cycle while the queue has room; s_axis_tready falls only when the queue
// holds three or more tokens. A stalled receiver fills the queue and then
// holds the input side; nothing is dropped. Reset clears the scan state,
// line 1, column 0, and empties the queue. The end-of-input transfer flushes
// a pending token, emits EOF and returns the scanner to its reset state.
// ----------------------------------------------------------------------------
`default_nettype none
module keyword_lexer_stream import klx_pkg::*; #(
    parameter int TEXT_BYTES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] char_code
    input  wire logic         s_axis_tuser,   // [0] cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [4:0] token_kind, [20:5] start_line, [36:21] start_column,
    // [100:37] text_first, [164:101] text_second, [168:165] text_length, rest 0
    output logic [175:0]      m_axis_tdata,
    output logic              m_axis_tlast
);
    logic       in_v_reg;
    logic       in_cmd_reg;
    logic [7:0] in_char_reg;
    logic       room;
    logic       fire;
    emit_pair_t pair;
    token_t     tok;

    // Input register advances when the scanner consumes it
    assign fire = in_v_reg && room;
    assign s_axis_tready = !in_v_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg <= s_axis_tuser;
            in_char_reg <= s_axis_tdata;
        end
    end

    klx_scanner #(.TEXT_BYTES(TEXT_BYTES)) u_scan (
        .aclk(aclk), .aresetn(aresetn), .in_fire(fire),
        .in_cmd(in_cmd_reg), .in_char(in_char_reg), .emit_out(pair)
    );

    klx_out_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(fire), .pair(pair), .room(room),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_tok(tok),
        .out_last(m_axis_tlast)
    );

    // Pack result fields, low field first
    assign m_axis_tdata = {7'h0, tok.len, 8'h0, tok.text[119:64], tok.text[63:0],
                           tok.column, tok.line, tok.kind};

endmodule
`default_nettype wire

[design/klx_checker.sv]
// ----------------------------------------------------------------------------
// Keyword lexer port checker
// Port-level properties of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyword_lexer_stream_defines.svh"
module klx_checker import klx_pkg::*; (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         s_axis_tuser,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [175:0] m_axis_tdata,
    input wire logic         m_axis_tlast
);
    // An EOF token always closes its input's group
    `KLX_ASSERT_IMPL(a_eof_last, aclk, aresetn,
        m_axis_tvalid && m_axis_tdata[4:0] == K_EOF, m_axis_tlast)
    // Kinds stay inside the defined range
    `KLX_ASSERT_IMPL(a_kind_range, aclk, aresetn, m_axis_tvalid,
        m_axis_tdata[4:0] <= K_ERROR)
    // Lines never read zero
    `KLX_ASSERT_IMPL(a_line_nonzero, aclk, aresetn, m_axis_tvalid,
        m_axis_tdata[20:5] != 16'd0)
    // A stalled result holds
    `KLX_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    // A stalled source transfer holds its command
    `KLX_ASSERT_NEXT(a_src_hold, aclk, aresetn, s_axis_tvalid && !s_axis_tready,
        s_axis_tvalid && $stable(s_axis_tuser))
endmodule

bind keyword_lexer_stream klx_checker u_klx_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire
